/* rtl/core/b64u_pkg.sv */
// Package for the base64url stream encoder: job type, constants, alphabet.
// No dependencies; used by the front, queue, back end, top level and testbench.
package b64u_pkg;

    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam logic [15:0] CAP_RESET       = 16'd1024;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [5:0] sextet0;
        logic [5:0] sextet1;
        logic       two;
        logic       last;
    } t_job;

    function automatic logic [7:0] f_b64u_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = w + 8'd65;
        end else if (v < 6'd52) begin
            c = w + 8'd71;
        end else if (v < 6'd62) begin
            c = w - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'd45;
        end else begin
            c = 8'd95;
        end
        return c;
    endfunction

endpackage

/* rtl/core/b64u_if.sv */
// Stream interfaces of the base64url encoder: byte input and character output.
// Depends on nothing; instantiated by the environment around the top level.
interface b64u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       error;
    logic       last_char;

    modport source (output valid, output out_char, output error, output last_char, input ready);
    modport sink   (input valid, input out_char, input error, input last_char, output ready);
endinterface

/* rtl/core/b64u_front.sv */
// Front end: accepts input beats, tracks group phase, splits bytes into sextet jobs.
// Depends on b64u_pkg and b64u_in_if.
module b64u_front
    import b64u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64u_in_if.sink     i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] w_b;

    assign w_b        = i_in.data_byte;
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_job.last = i_in.last_byte;
        case (r_phase)
            PH_ONE: begin
                o_job.sextet0 = {r_left[1:0], w_b[7:4]};
                o_job.sextet1 = {w_b[3:0], 2'b00};
                o_job.two     = i_in.last_byte;
                n_phase       = PH_TWO;
                n_left        = w_b[3:0];
            end
            PH_TWO: begin
                o_job.sextet0 = {r_left, w_b[7:6]};
                o_job.sextet1 = w_b[5:0];
                o_job.two     = 1'b1;
                n_phase       = PH_START;
                n_left        = 4'd0;
            end
            default: begin
                o_job.sextet0 = w_b[7:2];
                o_job.sextet1 = {w_b[1:0], 4'b0000};
                o_job.two     = i_in.last_byte;
                n_phase       = PH_ONE;
                n_left        = {2'b00, w_b[1:0]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= 4'd0;
        end else if (o_push) begin
            if (i_in.last_byte) begin
                r_phase <= PH_START;
                r_left  <= 4'd0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
            end
        end
    end

endmodule

/* rtl/core/b64u_queue.sv */
// Small register FIFO of sextet jobs between front and back end.
// Depends on b64u_pkg.
module b64u_queue
    import b64u_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_job                       i_job,
    input  logic                       i_pop,
    output t_job                       o_head,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/b64u_back.sv */
// Back end: emits characters from queued jobs, checks capacity, handles abort.
// Depends on b64u_pkg and b64u_out_if.
module b64u_back
    import b64u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_cap,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    b64u_out_if.source  o_out
);

    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_err;
    logic        r_out_last;
    logic [15:0] r_count;
    logic        r_aborted;
    logic        r_idx;

    logic        w_free;
    logic        w_go;
    logic        w_ok;
    logic        w_final;
    logic        w_done;
    logic [5:0]  w_sextet;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.error     = r_out_err;
    assign o_out.last_char = r_out_last;

    assign w_free   = !r_out_valid || o_out.ready;
    assign w_go     = !i_empty && !r_aborted && w_free;
    assign w_ok     = ({1'b0, r_count} + 17'd1) < {1'b0, i_cap};
    assign w_sextet = r_idx ? i_head.sextet1 : i_head.sextet0;
    assign w_final  = r_idx ? i_head.last : (i_head.last && !i_head.two);
    assign w_done   = r_idx || !i_head.two;
    assign o_pop    = (!i_empty && r_aborted) || (w_go && (!w_ok || w_done));

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_char <= w_ok ? f_b64u_char(w_sextet) : 8'd0;
            r_out_err  <= !w_ok;
            r_out_last <= w_ok ? w_final : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= 16'd0;
            r_aborted   <= 1'b0;
            r_idx       <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (!i_empty && r_aborted) begin
                if (i_head.last) begin
                    r_aborted <= 1'b0;
                    r_count   <= 16'd0;
                end
            end else if (w_go) begin
                if (!w_ok) begin
                    r_idx     <= 1'b0;
                    r_count   <= 16'd0;
                    r_aborted <= !i_head.last;
                end else if (!w_done) begin
                    r_idx   <= 1'b1;
                    r_count <= r_count + 16'd1;
                end else begin
                    r_idx   <= 1'b0;
                    r_count <= i_head.last ? 16'd0 : r_count + 16'd1;
                end
            end
        end
    end

endmodule

/* rtl/core/base64url_stream_encoder_top.sv */
// Base64url encoder, no padding. Accepted bytes are queued as jobs, then the back end
// registers the results. Back end issues one result per cycle while the output is
// free; the front takes a byte per cycle while the job queue has room, so bursts
// stall on it. Synchronous active-low reset clears phase, count, abort, queue and
// output valid, and sets output capacity to 1024.
// Depends on b64u_pkg, b64u_if, b64u_front, b64u_queue, b64u_back.
module base64url_stream_encoder_top
    import b64u_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    b64u_in_if.sink     i_in,
    b64u_out_if.source  o_out
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]   r_cap;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_q_count;
    t_job          w_job;
    t_job          w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    b64u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_q_count)
    );

    b64u_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.out_char == 8'd0 && o_out.last_char)
        else $error("error result malformed");

    a_beat_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_q_count != '0)
        else $error("accepted beat not queued");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && w_q_count == '0)
        else $error("state not cleared by reset");

endmodule

/* sim/base64url_stream_encoder_top_tb.sv */
// Self-checking testbench for base64url_stream_encoder_top: directed table, then random
// messages under several capacities and idle patterns, with a built-in character predictor.
// Depends on b64u_pkg, b64u_if and the RTL of the encoder.
`timescale 1ns / 1ps

module base64url_stream_encoder_top_tb;
    import b64u_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int BEATS_PER_LEG  = 100;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       lst;
    } t_char_beat;

    typedef enum logic {
        ROW_BYTE,
        ROW_CAP
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [15:0] cap;
        logic [7:0] data;
        logic       lst;
        logic       typed;
        logic [1:0] n_typed;
        t_char_beat t0;
        t_char_beat t1;
    } t_stim_row;

    localparam t_char_beat NO_BEAT  = '{8'h00, 1'b0, 1'b0};
    localparam t_char_beat ERR_BEAT = '{8'h00, 1'b1, 1'b1};

    // typed rows carry their own expected beats; the rest go through the predictor
    localparam t_stim_row DIRECTED [27] = '{
        '{ROW_BYTE, 16'd0,     8'h00, 1'b1, 1'b1, 2'd2, '{"A", 1'b0, 1'b0}, '{"A", 1'b0, 1'b1}},
        '{ROW_BYTE, 16'd0,     8'hFF, 1'b1, 1'b1, 2'd2, '{"_", 1'b0, 1'b0}, '{"w", 1'b0, 1'b1}},
        '{ROW_BYTE, 16'd0,     8'hFB, 1'b0, 1'b1, 2'd1, '{"-", 1'b0, 1'b0}, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'hFF, 1'b0, 1'b1, 2'd1, '{"_", 1'b0, 1'b0}, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'hBF, 1'b1, 1'b1, 2'd2, '{"-", 1'b0, 1'b0}, '{"_", 1'b0, 1'b1}},
        '{ROW_BYTE, 16'd0,     8'h4D, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h61, 1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd0,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h12, 1'b0, 1'b1, 2'd1, ERR_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h34, 1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h56, 1'b1, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h00, 1'b1, 1'b1, 2'd1, ERR_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd1,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'hAA, 1'b1, 1'b1, 2'd1, ERR_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd4,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h00, 1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h80, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd2,     8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h01, 1'b0, 1'b1, 2'd1, ERR_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h02, 1'b1, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd65535, 8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h5A, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'hA5, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BYTE, 16'd0,     8'h3C, 1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_CAP,  16'd1024,  8'h00, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    b64u_in_if  byte_if ();
    b64u_out_if char_if ();

    base64url_stream_encoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_if),
        .o_out       (char_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // encoder shadow state
    t_phase      enc_phase;
    logic [3:0]  enc_left;
    logic [15:0] enc_count;
    logic        enc_aborted;
    logic [15:0] cap_shadow;

    t_char_beat  pending_chars [$];
    int          err_count = 0;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          stall_reqs;

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        return ALPHABET[511 - 8 * s -: 8];
    endfunction

    function automatic logic room_left();
        return ({1'b0, enc_count} + 17'd1) < {1'b0, cap_shadow};
    endfunction

    function automatic void clear_message();
        enc_phase   = PH_START;
        enc_left    = 4'd0;
        enc_count   = 16'd0;
        enc_aborted = 1'b0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic lst, output int n,
                                        output t_char_beat r0, output t_char_beat r1);
        logic [5:0] s0;
        logic [5:0] s1;
        logic       both;
        t_phase     nph;
        logic [3:0] nleft;
        logic       ok;
        n  = 0;
        r0 = NO_BEAT;
        r1 = NO_BEAT;
        if (enc_aborted) begin
            if (lst) clear_message();
            return;
        end
        case (enc_phase)
            PH_ONE: begin
                s0    = {enc_left[1:0], b[7:4]};
                s1    = {b[3:0], 2'b00};
                both  = lst;
                nph   = PH_TWO;
                nleft = b[3:0];
            end
            PH_TWO: begin
                s0    = {enc_left, b[7:6]};
                s1    = b[5:0];
                both  = 1'b1;
                nph   = PH_START;
                nleft = 4'd0;
            end
            default: begin
                s0    = b[7:2];
                s1    = {b[1:0], 4'b0000};
                both  = lst;
                nph   = PH_ONE;
                nleft = {2'b00, b[1:0]};
            end
        endcase
        ok = room_left();
        n  = 1;
        if (ok) begin
            r0 = t_char_beat'{sextet_char(s0), 1'b0, lst && !both};
            enc_count = enc_count + 16'd1;
        end else begin
            r0 = ERR_BEAT;
        end
        if (ok && both) begin
            ok = room_left();
            n  = 2;
            if (ok) begin
                r1 = t_char_beat'{sextet_char(s1), 1'b0, lst};
                enc_count = enc_count + 16'd1;
            end else begin
                r1 = ERR_BEAT;
            end
        end
        if (lst) begin
            clear_message();
        end else if (!ok) begin
            enc_aborted = 1'b1;
        end else begin
            enc_phase = nph;
            enc_left  = nleft;
        end
    endfunction

    // offer one byte, wait for its beat, then queue what it should produce
    task automatic offer_byte(input logic [7:0] b, input logic lst, input logic typed,
                              input int n_typed, input t_char_beat t0, input t_char_beat t1);
        int         n;
        t_char_beat r0;
        t_char_beat r1;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= lst;
        do @(posedge i_clk); while (byte_if.ready !== 1'b1);
        encode_byte(b, lst, n, r0, r1);
        if (typed) begin
            n  = n_typed;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0) pending_chars.push_back(r0);
        if (n > 1) pending_chars.push_back(r1);
    endtask

    task automatic write_cap(input logic [15:0] v);
        byte_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_shadow = v;
    endtask

    // result side: check each accepted beat, then pick next ready
    initial begin
        t_char_beat want;
        int         hold;
        int         stall_seen;
        hold       = 0;
        stall_seen = 0;
        char_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && char_if.valid === 1'b1 && char_if.ready === 1'b1) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected beat: out_char %h error %b last_char %b",
                           char_if.out_char, char_if.error, char_if.last_char);
                    err_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (char_if.out_char !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, char_if.out_char);
                        err_count++;
                    end
                    if (char_if.error !== want.err) begin
                        $error("error: expected %b, got %b", want.err, char_if.error);
                        err_count++;
                    end
                    if (char_if.last_char !== want.lst) begin
                        $error("last_char: expected %b, got %b", want.lst, char_if.last_char);
                        err_count++;
                    end
                end
            end
            if (stall_reqs != stall_seen) begin
                stall_seen = stall_reqs;
                hold       = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                char_if.ready <= 1'b0;
            end else begin
                char_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
                (char_if.valid === 1'b1 && char_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("base64url_stream_encoder_top_tb: done, errors");
        $finish;
    end

    initial begin
        t_stim_row   row;
        int          useful;
        int          msg_left;
        logic [7:0]  b;
        logic [15:0] cap;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 16'd0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'd0;
        byte_if.last_byte <= 1'b0;
        src_idle_pct      <= 0;
        sink_idle_pct     <= 0;
        stall_reqs        <= 0;
        msg_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cap_shadow = CAP_RESET;
        clear_message();

        for (int i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CAP) begin
                write_cap(row.cap);
            end else begin
                offer_byte(row.data, row.lst, row.typed, int'(row.n_typed), row.t0, row.t1);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct  <= (mode == 0) ? 38 : (mode == 1) ? 87 : 0;
            sink_idle_pct <= (mode == 0) ? 87 : (mode == 1) ? 38 : 0;
            for (int leg = 0; leg < 5; leg++) begin
                case ($urandom_range(0, 7))
                    0:       cap = 16'($urandom_range(0, 1));
                    1:       cap = 16'($urandom_range(2, 8));
                    2:       cap = 16'($urandom_range(9, 40));
                    3:       cap = 16'd65535;
                    4:       cap = CAP_RESET;
                    default: cap = 16'($urandom_range(41, 2000));
                endcase
                // leg boundaries may fall inside a message, so writes land mid-message too
                write_cap(cap);
                if (mode == 2 && leg == 1) stall_reqs <= stall_reqs + 1;
                useful = 0;
                while (useful < BEATS_PER_LEG) begin
                    if (msg_left == 0) begin
                        msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                               : $urandom_range(1, 12);
                    end
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    useful++;
                    offer_byte(b, msg_left == 1, 1'b0, 0, NO_BEAT, NO_BEAT);
                    msg_left--;
                end
            end
        end

        byte_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("base64url_stream_encoder_top_tb: done, clean");
        end else begin
            $display("base64url_stream_encoder_top_tb: done, errors");
        end
        $finish;
    end

endmodule
